[hdl/ir_pulse_frame_decoder_core_assert.svh]
// ----------------------------------------------------------------------------
// IR frame decoder assertion macros
// Shared concurrent assertion forms for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_FRAME_DECODER_CORE_ASSERT_SVH
`define IR_PULSE_FRAME_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define IRPFD_ASSERT_NOW(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error("assertion failed: lbl");

// Next-cycle implication, off during reset.
`define IRPFD_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("assertion failed: lbl");

`endif

[hdl/irpfd_pkg.sv]
// ----------------------------------------------------------------------------
// IR frame decoder package
// Frame layout constants, register indexes and window helper.
// ----------------------------------------------------------------------------
`default_nettype none

package irpfd_pkg;

	localparam int DUR_W        = 16;
	localparam int PAYLOAD_BITS = 32;
	localparam int FRAME_LEN    = 2 * PAYLOAD_BITS + 3;
	localparam int POS_W        = $clog2(FRAME_LEN + 1);
	localparam int BIT_IDX_W    = $clog2(PAYLOAD_BITS);
	localparam int REG_COUNT    = 8;
	localparam int CFG_IDX_W    = 4;
	localparam int CFG_SEL_W    = $clog2(REG_COUNT);

	localparam logic [DUR_W-1:0] ZERO_SPACE_MIN = 16'd400;
	localparam logic [DUR_W-1:0] ZERO_SPACE_MAX = 16'd700;
	localparam logic [7:0]       BYTE_MASK      = 8'hff;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEAD_PULSE_MIN = 4'd0,
		REG_LEAD_PULSE_MAX = 4'd1,
		REG_LEAD_SPACE_MIN = 4'd2,
		REG_LEAD_SPACE_MAX = 4'd3,
		REG_BIT_PULSE_MIN  = 4'd4,
		REG_BIT_PULSE_MAX  = 4'd5,
		REG_ONE_SPACE_MIN  = 4'd6,
		REG_ONE_SPACE_MAX  = 4'd7
	} reg_idx_t;

	typedef logic [DUR_W-1:0] dur_t;

	localparam dur_t REG_RESET [REG_COUNT] = '{
		16'd8000, 16'd10000, 16'd4000, 16'd5000,
		16'd400, 16'd700, 16'd1500, 16'd1900
	};

	// register file slot of a register index
	function automatic logic [CFG_SEL_W-1:0] reg_sel(input reg_idx_t r);
		return r[CFG_SEL_W-1:0];
	endfunction

	// inclusive window test; an inverted window accepts nothing
	function automatic logic in_window(input dur_t v, input dur_t lo, input dur_t hi);
		return (v >= lo) && (v <= hi);
	endfunction

endpackage

`default_nettype wire

[hdl/ir_pulse_frame_decoder_core.sv]
// ----------------------------------------------------------------------------
// IR pulse frame decoder core
// Checks mark/space durations of an NEC style frame and emits one decoded
// address/command result per captured waveform.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                | accept
//  s_axis   | in  | tdata[15:0] duration, tlast last_sample | tvalid & tready
//  m_axis   | out | tdata[7:0] address, [15:8] command,     | tvalid & tready
//           |     | tuser frame_ok                          |
//  cfg      | in  | cfg_index register, cfg_wdata value     | cfg_we
//
//  One duration per cycle unless a last item is stalled; each item is held in
//  the input register, where the window compares and the frame state update
//  run, and a last item then loads the result register.
//  Reset clears frame state, thresholds go to their defaults.
//  A last item waits in the input register only while the result register is
//  full and not being taken; other items never stall.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ir_pulse_frame_decoder_core_assert.svh"

module ir_pulse_frame_decoder_core
	import irpfd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [DUR_W-1:0]     s_axis_tdata,  // [15:0] duration
	input  wire logic                 s_axis_tlast,  // last_sample
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [15:0]               m_axis_tdata,  // [7:0] address, [15:8] command
	output logic                      m_axis_tuser,  // frame_ok
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DUR_W-1:0]     cfg_wdata
);

	dur_t cfg_q [REG_COUNT];

	logic                    valid_s1;
	dur_t                    dur_s1;
	logic                    last_s1;

	logic [POS_W-1:0]        pos_q;
	logic [PAYLOAD_BITS-1:0] bits_q;
	logic                    failed_q;
	logic                    pulse_ok_q;

	logic                    out_free;
	logic                    s1_take;

	logic [POS_W-1:0]        pos_d;
	logic [PAYLOAD_BITS-1:0] bits_d;
	logic                    failed_d;
	logic                    pulse_ok_d;
	logic [BIT_IDX_W-1:0]    bit_idx;
	logic                    is_one;
	logic                    is_zero;
	logic [7:0]              addr_b;
	logic [7:0]              addr_inv_b;
	logic [7:0]              cmd_b;
	logic [7:0]              cmd_inv_b;
	logic                    frame_ok;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) cfg_q[i] <= REG_RESET[i];
		end else if (cfg_we && (cfg_index < CFG_IDX_W'(REG_COUNT))) begin
			cfg_q[cfg_index[CFG_SEL_W-1:0]] <= cfg_wdata;
		end
	end

	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign s1_take       = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || s1_take;

	// frame state update for the item in the input register
	always_comb begin
		pos_d      = pos_q;
		bits_d     = bits_q;
		failed_d   = failed_q;
		pulse_ok_d = pulse_ok_q;
		bit_idx    = BIT_IDX_W'(pos_q[POS_W-1:1] - 1'b1);
		is_one     = in_window(dur_s1, cfg_q[reg_sel(REG_ONE_SPACE_MIN)],
			cfg_q[reg_sel(REG_ONE_SPACE_MAX)]);
		is_zero    = in_window(dur_s1, ZERO_SPACE_MIN, ZERO_SPACE_MAX);
		if (pos_q < POS_W'(FRAME_LEN)) begin
			if (pos_q == '0) begin
				if (!in_window(dur_s1, cfg_q[reg_sel(REG_LEAD_PULSE_MIN)],
						cfg_q[reg_sel(REG_LEAD_PULSE_MAX)]))
					failed_d = 1'b1;
			end else if (pos_q == POS_W'(1)) begin
				if (!in_window(dur_s1, cfg_q[reg_sel(REG_LEAD_SPACE_MIN)],
						cfg_q[reg_sel(REG_LEAD_SPACE_MAX)]))
					failed_d = 1'b1;
			end else if (pos_q == POS_W'(FRAME_LEN - 1)) begin
				if (!in_window(dur_s1, cfg_q[reg_sel(REG_BIT_PULSE_MIN)],
						cfg_q[reg_sel(REG_BIT_PULSE_MAX)]))
					failed_d = 1'b1;
			end else if (!pos_q[0]) begin
				pulse_ok_d = in_window(dur_s1, cfg_q[reg_sel(REG_BIT_PULSE_MIN)],
					cfg_q[reg_sel(REG_BIT_PULSE_MAX)]);
			end else begin
				if (!pulse_ok_q) failed_d = 1'b1;
				if (is_one) bits_d[bit_idx] = 1'b1;
				else if (!is_zero) failed_d = 1'b1;
			end
			pos_d = pos_q + 1'b1;
		end
		addr_b     = bits_d[7:0];
		addr_inv_b = bits_d[15:8];
		cmd_b      = bits_d[23:16];
		cmd_inv_b  = bits_d[31:24];
		frame_ok   = (pos_d == POS_W'(FRAME_LEN)) && !failed_d &&
			(addr_b == (~addr_inv_b & BYTE_MASK)) && (cmd_b == (~cmd_inv_b & BYTE_MASK));
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			dur_s1  <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// frame state; clear after the last item of a waveform
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			bits_q     <= '0;
			failed_q   <= 1'b0;
			pulse_ok_q <= 1'b0;
		end else if (s1_take) begin
			if (last_s1) begin
				pos_q      <= '0;
				bits_q     <= '0;
				failed_q   <= 1'b0;
				pulse_ok_q <= 1'b0;
			end else begin
				pos_q      <= pos_d;
				bits_q     <= bits_d;
				failed_q   <= failed_d;
				pulse_ok_q <= pulse_ok_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (s1_take && last_s1) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take && last_s1) begin
			m_axis_tuser <= frame_ok;
			m_axis_tdata <= frame_ok ? {cmd_b, addr_b} : 16'd0;
		end
	end

	`IRPFD_ASSERT_NEXT(a_clear_after_last, clk, arst_n, s1_take && last_s1,
		pos_q == '0 && bits_q == '0 && !failed_q && !pulse_ok_q)
	`IRPFD_ASSERT_NEXT(a_result_loaded, clk, arst_n, s1_take && last_s1, m_axis_tvalid)
	`IRPFD_ASSERT_NOW(a_stall_only_when_full, clk, arst_n, valid_s1 && !s1_take,
		last_s1 && m_axis_tvalid && !m_axis_tready)
	`IRPFD_ASSERT_NOW(a_pos_bounded, clk, arst_n, 1'b1, pos_q <= POS_W'(FRAME_LEN))

endmodule

`default_nettype wire

[tb/ir_pulse_frame_decoder_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse frame decoder core testbench
// Streams NEC style frames (clean, corrupted, truncated, padded and noise)
// through the decoder under several threshold settings, predicts each decoded
// result and compares it with the result stream, with random gaps on both
// sides.
// ----------------------------------------------------------------------------
module ir_pulse_frame_decoder_core_test
	import irpfd_pkg::*;
;

	typedef struct packed {
		dur_t duration;
		logic last_sample;
	} ir_sample_t;

	typedef struct packed {
		logic       frame_ok;
		logic [7:0] address;
		logic [7:0] command;
	} ir_result_t;

	typedef enum int {
		FRM_CLEAN,
		FRM_PADDED,
		FRM_BAD_CHECK,
		FRM_GLITCH,
		FRM_TRUNCATED,
		FRM_NOISE
	} frame_kind_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [DUR_W-1:0]     s_axis_tdata = '0;
	logic                 s_axis_tlast = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [15:0]          m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DUR_W-1:0]     cfg_wdata = '0;

	ir_sample_t durations_pending[$];
	ir_result_t frames_due[$];
	ir_sample_t next_sample;
	ir_result_t seen_result;
	ir_result_t want_result;
	int         durations_queued = 0;
	int         durations_taken = 0;
	int         stim_count = 0;
	int         mismatches = 0;
	bit         calm = 1'b0;

	// decoder image: thresholds and frame state
	dur_t        win[REG_COUNT] = REG_RESET;
	int          dur_seen = 0;
	logic [31:0] payload_bits = '0;
	bit          frame_bad = 1'b0;
	bit          mark_ok = 1'b0;

	ir_pulse_frame_decoder_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit fits(input dur_t v, input dur_t lo, input dur_t hi);
		return v >= lo && v <= hi;
	endfunction

	task automatic decode_duration(input dur_t d, input logic last_sample);
		ir_result_t r;
		int slot;
		if (dur_seen < FRAME_LEN) begin
			if (dur_seen == 0) begin
				if (!fits(d, win[reg_sel(REG_LEAD_PULSE_MIN)], win[reg_sel(REG_LEAD_PULSE_MAX)]))
					frame_bad = 1'b1;
			end else if (dur_seen == 1) begin
				if (!fits(d, win[reg_sel(REG_LEAD_SPACE_MIN)], win[reg_sel(REG_LEAD_SPACE_MAX)]))
					frame_bad = 1'b1;
			end else if (dur_seen == FRAME_LEN - 1) begin
				if (!fits(d, win[reg_sel(REG_BIT_PULSE_MIN)], win[reg_sel(REG_BIT_PULSE_MAX)]))
					frame_bad = 1'b1;
			end else if (dur_seen % 2 == 0) begin
				mark_ok = fits(d, win[reg_sel(REG_BIT_PULSE_MIN)],
					win[reg_sel(REG_BIT_PULSE_MAX)]);
			end else begin
				slot = (dur_seen - 3) / 2;
				if (!mark_ok)
					frame_bad = 1'b1;
				// one window wins where it overlaps the zero window
				if (fits(d, win[reg_sel(REG_ONE_SPACE_MIN)], win[reg_sel(REG_ONE_SPACE_MAX)]))
					payload_bits[slot] = 1'b1;
				else if (!fits(d, ZERO_SPACE_MIN, ZERO_SPACE_MAX))
					frame_bad = 1'b1;
			end
			dur_seen++;
		end
		if (last_sample) begin
			r.frame_ok = dur_seen >= FRAME_LEN && !frame_bad &&
				payload_bits[7:0] == ~payload_bits[15:8] &&
				payload_bits[23:16] == ~payload_bits[31:24];
			r.address = r.frame_ok ? payload_bits[7:0] : 8'h00;
			r.command = r.frame_ok ? payload_bits[23:16] : 8'h00;
			frames_due.push_back(r);
			dur_seen = 0;
			payload_bits = '0;
			frame_bad = 1'b0;
			mark_ok = 1'b0;
		end
	endtask

	// driver: present the next request once the previous one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				decode_duration(s_axis_tdata, s_axis_tlast);
				durations_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (durations_pending.size() != 0 && (calm || $urandom_range(99) >= 31)) begin
					next_sample = durations_pending.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= next_sample.duration;
					s_axis_tlast <= next_sample.last_sample;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: random backpressure, check each decoded frame in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen_result = '{m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8]};
				if (frames_due.size() == 0) begin
					$display("%0t: unexpected result ok=%0b addr=%02h cmd=%02h", $time,
						seen_result.frame_ok, seen_result.address, seen_result.command);
					mismatches++;
				end else begin
					want_result = frames_due.pop_front();
					if (seen_result !== want_result) begin
						$display("%0t: mismatch, expected ok=%0b addr=%02h cmd=%02h, got ok=%0b addr=%02h cmd=%02h",
							$time, want_result.frame_ok, want_result.address,
							want_result.command, seen_result.frame_ok,
							seen_result.address, seen_result.command);
						mismatches++;
					end
				end
			end
			m_axis_tready <= calm || $urandom_range(99) >= 31;
		end
	end

	function automatic dur_t pick(input dur_t lo, input dur_t hi);
		if (lo > hi)
			return dur_t'($urandom);
		case ($urandom_range(3))
			0: return lo;
			1: return hi;
			default: return dur_t'($urandom_range(hi, lo));
		endcase
	endfunction

	task automatic push_sample(input dur_t d, input logic last_sample, input bit counted);
		durations_pending.push_back('{duration: d, last_sample: last_sample});
		durations_queued++;
		if (counted)
			stim_count++;
	endtask

	task automatic queue_frame();
		dur_t        seq[$];
		logic [31:0] payload;
		logic [7:0]  addr;
		logic [7:0]  cmd;
		frame_kind_t kind;
		int          roll;
		int          n;
		roll = $urandom_range(99);
		kind = roll < 40 ? FRM_CLEAN : roll < 50 ? FRM_PADDED : roll < 60 ? FRM_BAD_CHECK :
			roll < 75 ? FRM_GLITCH : roll < 85 ? FRM_TRUNCATED : FRM_NOISE;
		addr = 8'($urandom);
		cmd = 8'($urandom);
		payload = {~cmd, cmd, ~addr, addr};
		if (kind == FRM_BAD_CHECK) begin
			n = $urandom_range(31);
			payload[n] = ~payload[n];
		end
		if (kind == FRM_NOISE) begin
			n = $urandom_range(1, 8);
			repeat (n) seq.push_back(dur_t'($urandom));
		end else begin
			seq.push_back(pick(win[reg_sel(REG_LEAD_PULSE_MIN)], win[reg_sel(REG_LEAD_PULSE_MAX)]));
			seq.push_back(pick(win[reg_sel(REG_LEAD_SPACE_MIN)], win[reg_sel(REG_LEAD_SPACE_MAX)]));
			for (int i = 0; i < PAYLOAD_BITS; i++) begin
				seq.push_back(pick(win[reg_sel(REG_BIT_PULSE_MIN)],
					win[reg_sel(REG_BIT_PULSE_MAX)]));
				seq.push_back(payload[i] ?
					pick(win[reg_sel(REG_ONE_SPACE_MIN)], win[reg_sel(REG_ONE_SPACE_MAX)]) :
					pick(ZERO_SPACE_MIN, ZERO_SPACE_MAX));
			end
			seq.push_back(pick(win[reg_sel(REG_BIT_PULSE_MIN)], win[reg_sel(REG_BIT_PULSE_MAX)]));
			case (kind)
				FRM_GLITCH: begin
					// nudge a duration up or down by one, or replace it with a random value
					n = $urandom_range(FRAME_LEN - 1);
					if ($urandom_range(1))
						seq[n] = $urandom_range(1) ? seq[n] + 16'd1 : seq[n] - 16'd1;
					else
						seq[n] = dur_t'($urandom);
				end
				FRM_PADDED: begin
					n = ($urandom_range(9) == 0) ? $urandom_range(70, 90) : $urandom_range(1, 4);
					repeat (n) seq.push_back(dur_t'($urandom));
				end
				FRM_TRUNCATED: begin
					n = $urandom_range(1, FRAME_LEN - 1);
					while (seq.size() > n) void'(seq.pop_back());
				end
				default: ;
			endcase
		end
		foreach (seq[i])
			push_sample(seq[i], i == seq.size() - 1, i < FRAME_LEN);
	endtask

	// hold until every request is taken and every frame is back
	task automatic drain();
		while (durations_taken != durations_queued || frames_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input dur_t v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		if (idx < REG_COUNT)
			win[idx[CFG_SEL_W-1:0]] = v;
	endtask

	task automatic program_windows(input dur_t lims[REG_COUNT]);
		for (int i = 0; i < REG_COUNT; i++)
			write_reg(CFG_IDX_W'(i), lims[i]);
		// unmapped index: must leave every threshold alone
		write_reg(CFG_IDX_W'(REG_COUNT + $urandom_range(CFG_IDX_W'(-1) - REG_COUNT)),
			dur_t'($urandom));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int   ph;
		dur_t lims[REG_COUNT];
		dur_t lo_v;
		dur_t hi_v;
		dur_t swap_v;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short frames at the field extremes, reset thresholds
		push_sample(16'd0, 1'b1, 1'b1);
		push_sample(16'hffff, 1'b1, 1'b1);
		push_sample(16'hffff, 1'b0, 1'b1);
		push_sample(16'd0, 1'b0, 1'b1);
		push_sample(16'd1, 1'b1, 1'b1);
		push_sample(16'd8000, 1'b0, 1'b1);
		push_sample(16'd5000, 1'b0, 1'b1);
		push_sample(16'd400, 1'b0, 1'b1);
		push_sample(16'd1900, 1'b1, 1'b1);
		push_sample(16'd10000, 1'b0, 1'b1);
		push_sample(16'd4000, 1'b0, 1'b1);
		push_sample(16'd700, 1'b0, 1'b1);
		push_sample(16'd1500, 1'b0, 1'b1);
		push_sample(16'hffff, 1'b0, 1'b1);
		push_sample(16'h8000, 1'b1, 1'b1);
		drain();

		for (ph = 0; stim_count < 1650; ph++) begin
			case (ph)
				0: lims = REG_RESET;
				// one-space window overlapping the zero-space window
				1: lims = '{16'd8000, 16'd10000, 16'd4000, 16'd5000,
					16'd400, 16'd700, 16'd600, 16'd900};
				2: lims = '{default: 16'd0};
				3: lims = '{default: 16'hffff};
				4: lims = '{16'd0, 16'hffff, 16'd0, 16'hffff, 16'd0, 16'hffff, 16'd0, 16'hffff};
				5: lims = '{16'hffff, 16'd0, 16'hffff, 16'd0, 16'hffff, 16'd0, 16'hffff, 16'd0};
				6: lims = REG_RESET;
				default: begin
					for (int i = 0; i < REG_COUNT; i += 2) begin
						lo_v = dur_t'($urandom);
						hi_v = dur_t'($urandom);
						if ($urandom_range(4) != 0 && lo_v > hi_v) begin
							swap_v = lo_v;
							lo_v = hi_v;
							hi_v = swap_v;
						end
						lims[i] = lo_v;
						lims[i + 1] = hi_v;
					end
				end
			endcase
			program_windows(lims);
			calm = (ph == 4);
			repeat (3) queue_frame();
			drain();
		end
		calm = 1'b0;

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("ir_pulse_frame_decoder_core_test: clean");
		else
			$display("ir_pulse_frame_decoder_core_test: errors");
		$finish;
	end

	initial begin
		#(2_000_000);
		$display("ir_pulse_frame_decoder_core_test: errors");
		$finish;
	end

endmodule
